// ----- src/hsvf_pkg.sv -----
package hsvf_pkg;

   localparam int PIX_W     = 16;   // rgb565 pixel
   localparam int CH_W      = 8;    // expanded channel, h, s and v
   localparam int DVD_W     = 16;   // divider dividend
   localparam int QUO_W     = 8;    // divider quotient
   localparam int DEG_W     = 9;    // hue in degrees, 0..359
   localparam int HSC_W     = 10;   // (deg*17)>>3, at most 762
   localparam int RSP_W     = 32;   // result beat, padded to bytes
   localparam int RSP_USED  = 1 + 3 * CH_W;
   localparam int CFG_IDX_W = 3;

   localparam int DIV_STAGES_DEF = 4;

   // largest hue a pixel can produce: 359 degrees scaled by 255/360
   localparam logic [CH_W-1:0] HUE_MAX = 8'd254;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_VAL_LOW  = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_VAL_HIGH = 3'd5;

   // which channel holds the maximum (red checked first, then green)
   typedef logic [1:0] hue_case_type;
   localparam hue_case_type HC_RED   = 2'd0;
   localparam hue_case_type HC_GREEN = 2'd1;
   localparam hue_case_type HC_BLUE  = 2'd2;

   // per-pixel context that rides alongside the dividers
   typedef struct packed {
      logic [CH_W-1:0] val;
      hue_case_type    hcase;
      logic            neg;      // hue numerator was negative
      logic            sat_zero; // max is zero
      logic            hue_zero; // max equals min
   } side_type;

   // c*255/31 and c*255/63, truncated, via reciprocal multiply (exact over the range)
   localparam logic [31:0] W5_MUL = 32'd34501755;  // 255 * ceil(2^22/31)
   localparam logic [31:0] W6_MUL = 32'd16977135;  // 255 * ceil(2^22/63)

   function automatic logic [CH_W-1:0] widen5(input logic [4:0] c);
      logic [31:0] prod;
      prod = 32'(c) * W5_MUL;
      return prod[29:22];
   endfunction

   function automatic logic [CH_W-1:0] widen6(input logic [5:0] c);
      logic [31:0] prod;
      prod = 32'(c) * W6_MUL;
      return prod[29:22];
   endfunction

endpackage

// ----- src/rgb565_hsv_color_range_filter.sv -----
// channel | dir | beat contents
// --------+-----+-----------------------------------------------------------
// req_    | in  | tdata[15:0] pixel_rgb565
// rsp_    | out | tdata[0] in_range, [8:1] hue, [16:9] saturation, [24:17] brightness
// csr_    | in  | wen/addr/wdata, one 8-bit register per write, no read-back
//
// one beat per clock in and out while rsp_tready is high; the pipe runs through the two
// restoring dividers (saturation and hue), QUO_W/DIV_STAGES bits per stage
// every stage holds a valid bit; a stage loads when it is empty or its successor moves,
// so a stalled rsp_ side stops only the full stages behind it and bubbles squeeze out
// synchronous reset clears the valid bits and returns the registers to full-range bounds
module rgb565_hsv_color_range_filter #(
   parameter int DIV_STAGES = hsvf_pkg::DIV_STAGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // pixel beats
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hsvf_pkg::PIX_W-1:0]      req_tdata,   // [15:0] pixel_rgb565
   // result beats
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hsvf_pkg::RSP_W-1:0]      rsp_tdata,   // in_range, hue, saturation, brightness
   // register writes
   input  logic                            csr_wen,
   input  logic [hsvf_pkg::CFG_IDX_W-1:0]  csr_addr,
   input  logic [hsvf_pkg::CH_W-1:0]       csr_wdata
);
   import hsvf_pkg::*;

   // stage positions in the valid vector
   localparam int ST1 = 0;               // expanded channels
   localparam int ST2 = 1;               // max, diff, hue case
   localparam int ST3 = 2;               // dividends
   localparam int DV0 = 3;               // first divider stage
   localparam int ST4 = DV0 + DIV_STAGES; // degrees, saturation
   localparam int ST5 = ST4 + 1;         // degrees * 17 / 8
   localparam int ST6 = ST5 + 1;         // scaled hue
   localparam int ST7 = ST6 + 1;         // output register
   localparam int NST = ST7 + 1;

   localparam logic [DEG_W-1:0] DEG_FULL  = 9'd360;
   localparam logic [DEG_W-1:0] DEG_GREEN = 9'd120;
   localparam logic [DEG_W-1:0] DEG_BLUE  = 9'd240;

   // configuration
   logic [CH_W-1:0] hue_low_ff, hue_high_ff, sat_low_ff, sat_high_ff, val_low_ff, val_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff  <= '0;
         hue_high_ff <= '1;
         sat_low_ff  <= '0;
         sat_high_ff <= '1;
         val_low_ff  <= '0;
         val_high_ff <= '1;
      end else if (csr_wen) begin
         unique case (csr_addr)
            REG_HUE_LOW:  hue_low_ff  <= csr_wdata;
            REG_HUE_HIGH: hue_high_ff <= csr_wdata;
            REG_SAT_LOW:  sat_low_ff  <= csr_wdata;
            REG_SAT_HIGH: sat_high_ff <= csr_wdata;
            REG_VAL_LOW:  val_low_ff  <= csr_wdata;
            REG_VAL_HIGH: val_high_ff <= csr_wdata;
            default: ;    // unused indexes are dropped
         endcase
      end
   end

   // valid bits and per-stage advance
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_src;
   logic [NST:0]   adv;

   always_comb begin
      adv[NST] = rsp_tready;
      for (int k = NST - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign vld_src    = {vld_ff[NST-2:0], req_tvalid};
   assign req_tready = adv[ST1];
   assign rsp_tvalid = vld_ff[ST7];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (adv[k]) vld_ff[k] <= vld_src[k];
         end
      end
   end

   // stage 1: expand 5/6-bit channels to 8 bits
   logic [CH_W-1:0] r1_ff, g1_ff, b1_ff;

   always_ff @(posedge clock) begin
      if (adv[ST1]) begin
         r1_ff <= widen5(req_tdata[15:11]);
         g1_ff <= widen6(req_tdata[10:5]);
         b1_ff <= widen5(req_tdata[4:0]);
      end
   end

   // stage 2: max, min, hue case and hue numerator magnitude
   logic [CH_W-1:0] mx2_in, mn2_in, diff2_in, mag2_in, opa2, opb2;
   hue_case_type    hc2_in;
   logic            neg2_in;

   logic [CH_W-1:0] v2_ff, diff2_ff, mag2_ff;
   hue_case_type    hc2_ff;
   logic            neg2_ff;

   always_comb begin
      mx2_in = (r1_ff > g1_ff) ? ((r1_ff > b1_ff) ? r1_ff : b1_ff)
                               : ((g1_ff > b1_ff) ? g1_ff : b1_ff);
      mn2_in = (r1_ff < g1_ff) ? ((r1_ff < b1_ff) ? r1_ff : b1_ff)
                               : ((g1_ff < b1_ff) ? g1_ff : b1_ff);
      diff2_in = mx2_in - mn2_in;
      // ties go to red, then green
      if (mx2_in == r1_ff) begin
         hc2_in = HC_RED;
         opa2   = g1_ff;
         opb2   = b1_ff;
      end else if (mx2_in == g1_ff) begin
         hc2_in = HC_GREEN;
         opa2   = b1_ff;
         opb2   = r1_ff;
      end else begin
         hc2_in = HC_BLUE;
         opa2   = r1_ff;
         opb2   = g1_ff;
      end
      neg2_in = opa2 < opb2;
      mag2_in = neg2_in ? (opb2 - opa2) : (opa2 - opb2);
   end

   always_ff @(posedge clock) begin
      if (adv[ST2]) begin
         v2_ff    <= mx2_in;
         diff2_ff <= diff2_in;
         mag2_ff  <= mag2_in;
         hc2_ff   <= hc2_in;
         neg2_ff  <= neg2_in;
      end
   end

   // stage 3: dividends diff*255 and |num|*60
   logic [DVD_W-1:0] sdvd3_ff, hdvd3_ff;
   logic [CH_W-1:0]  sdvs3_ff, hdvs3_ff;
   side_type         side3_ff;

   always_ff @(posedge clock) begin
      if (adv[ST3]) begin
         sdvd3_ff          <= DVD_W'(diff2_ff) * DVD_W'(255);
         hdvd3_ff          <= DVD_W'(mag2_ff) * DVD_W'(60);
         sdvs3_ff          <= v2_ff;
         hdvs3_ff          <= diff2_ff;
         side3_ff.val      <= v2_ff;
         side3_ff.hcase    <= hc2_ff;
         side3_ff.neg      <= neg2_ff;
         side3_ff.sat_zero <= (v2_ff == '0);
         side3_ff.hue_zero <= (diff2_ff == '0);
      end
   end

   // divider stages: both quotients fit in 8 bits since |num| <= diff <= max
   logic [QUO_W-1:0] sat_quo, hue_quo;

   hsvf_div #(.STAGES(DIV_STAGES)) u_sat_div (
      .clock    (clock),
      .en       (adv[DV0 +: DIV_STAGES]),
      .dividend (sdvd3_ff),
      .divisor  (sdvs3_ff),
      .quotient (sat_quo)
   );

   hsvf_div #(.STAGES(DIV_STAGES)) u_hue_div (
      .clock    (clock),
      .en       (adv[DV0 +: DIV_STAGES]),
      .dividend (hdvd3_ff),
      .divisor  (hdvs3_ff),
      .quotient (hue_quo)
   );

   // context follows the divider stages
   side_type side_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (adv[DV0 + j]) begin
            if (j == 0) side_ff[j] <= side3_ff;
            else        side_ff[j] <= side_ff[j-1];
         end
      end
   end

   // stage 4: signed quotient plus sector offset, wrapped into 0..359
   side_type         side4;
   logic [DEG_W-1:0] q4, deg4_in;
   logic [CH_W-1:0]  s4_in;

   logic [DEG_W-1:0] deg4_ff;
   logic [CH_W-1:0]  s4_ff, v4_ff;

   assign side4 = side_ff[DIV_STAGES-1];
   assign q4    = DEG_W'(hue_quo);

   always_comb begin
      unique case (side4.hcase)
         HC_RED: begin
            // a negative zero quotient stays at zero degrees
            if (side4.neg && q4 != '0) deg4_in = DEG_FULL - q4;
            else                       deg4_in = q4;
         end
         HC_GREEN: deg4_in = side4.neg ? (DEG_GREEN - q4) : (DEG_GREEN + q4);
         HC_BLUE:  deg4_in = side4.neg ? (DEG_BLUE - q4) : (DEG_BLUE + q4);
         default:  deg4_in = '0;
      endcase
      if (side4.hue_zero) deg4_in = '0;
      s4_in = side4.sat_zero ? '0 : sat_quo;
   end

   always_ff @(posedge clock) begin
      if (adv[ST4]) begin
         deg4_ff <= deg4_in;
         s4_ff   <= s4_in;
         v4_ff   <= side4.val;
      end
   end

   // stages 5 and 6: deg*255/360 = floor(floor(deg*17/8)/3), the /3 as *683>>11
   logic [12:0]      deg17_5;
   logic [HSC_W-1:0] y5_ff;
   logic [CH_W-1:0]  s5_ff, v5_ff;

   assign deg17_5 = 13'(deg4_ff) * 13'd17;

   always_ff @(posedge clock) begin
      if (adv[ST5]) begin
         y5_ff <= deg17_5[12:3];
         s5_ff <= s4_ff;
         v5_ff <= v4_ff;
      end
   end

   logic [18:0]     y683_6;
   logic [CH_W-1:0] h6_ff, s6_ff, v6_ff;

   assign y683_6 = 19'(y5_ff) * 19'd683;

   always_ff @(posedge clock) begin
      if (adv[ST6]) begin
         h6_ff <= y683_6[18:11];
         s6_ff <= s5_ff;
         v6_ff <= v5_ff;
      end
   end

   // stage 7: range compare into the output register
   logic sv_ok7, hue_ok7;
   logic rng7_ff;
   logic [CH_W-1:0] h7_ff, s7_ff, v7_ff;

   always_comb begin
      sv_ok7 = (s6_ff >= sat_low_ff) && (s6_ff <= sat_high_ff) &&
               (v6_ff >= val_low_ff) && (v6_ff <= val_high_ff);
      // low above high means the hue window wraps through zero
      if (hue_low_ff <= hue_high_ff)
         hue_ok7 = (h6_ff >= hue_low_ff) && (h6_ff <= hue_high_ff);
      else
         hue_ok7 = (h6_ff >= hue_low_ff) || (h6_ff <= hue_high_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[ST7]) begin
         rng7_ff <= sv_ok7 && hue_ok7;
         h7_ff   <= h6_ff;
         s7_ff   <= s6_ff;
         v7_ff   <= v6_ff;
      end
   end

   assign rsp_tdata = {(RSP_W - RSP_USED)'(0), v7_ff, s7_ff, h7_ff, rng7_ff};

   // checks
   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output stage is empty");

   a_black_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && v7_ff == '0 |-> h7_ff == '0 && s7_ff == '0)
      else $error("black pixel with nonzero hue or saturation");

   a_gray_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && s7_ff == '0 |-> h7_ff == '0)
      else $error("zero saturation with nonzero hue");

   a_hue_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> h7_ff <= HUE_MAX)
      else $error("hue beyond largest reachable value");

endmodule

// ----- src/hsvf_div.sv -----
module hsvf_div #(
   parameter int STAGES = hsvf_pkg::DIV_STAGES_DEF
) (
   input  logic                         clock,
   input  logic [STAGES-1:0]            en,
   input  logic [hsvf_pkg::DVD_W-1:0]   dividend,
   input  logic [hsvf_pkg::CH_W-1:0]    divisor,
   output logic [hsvf_pkg::QUO_W-1:0]   quotient
);
   import hsvf_pkg::*;

   localparam int STEPS = QUO_W / STAGES;

   logic [DVD_W-1:0] rem_ff [STAGES];
   logic [DVD_W-1:0] rem_in [STAGES];
   logic [CH_W-1:0]  dvs_ff [STAGES];
   logic [CH_W-1:0]  dvs_in [STAGES];
   logic [QUO_W-1:0] quo_ff [STAGES];
   logic [QUO_W-1:0] quo_in [STAGES];

   // restoring division, STEPS quotient bits per stage, msb first
   always_comb begin
      logic [DVD_W-1:0] rem;
      logic [CH_W-1:0]  dvs;
      logic [QUO_W-1:0] quo;
      logic [DVD_W-1:0] trial;
      for (int j = 0; j < STAGES; j++) begin
         if (j == 0) begin
            rem = dividend;
            dvs = divisor;
            quo = '0;
         end else begin
            rem = rem_ff[j-1];
            dvs = dvs_ff[j-1];
            quo = quo_ff[j-1];
         end
         for (int s = 0; s < STEPS; s++) begin
            trial = DVD_W'(dvs) << (QUO_W - 1 - j * STEPS - s);
            if (rem >= trial) begin
               rem = rem - trial;
               quo[QUO_W - 1 - j * STEPS - s] = 1'b1;
            end
         end
         rem_in[j] = rem;
         dvs_in[j] = dvs;
         quo_in[j] = quo;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < STAGES; j++) begin
         if (en[j]) begin
            rem_ff[j] <= rem_in[j];
            dvs_ff[j] <= dvs_in[j];
            quo_ff[j] <= quo_in[j];
         end
      end
   end

   assign quotient = quo_ff[STAGES-1];

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import hsvf_pkg::*;

   // csr indexes past the last register, writes there must be dropped
   localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

   // cycles without any beat on either side before the run is declared hung
   localparam int STALL_LIMIT = 3000;
   // quiet cycles after the last result, more than the pipe depth
   localparam int TAIL_CYCLES = 24;

   // one decoded result beat
   typedef struct packed {
      logic            in_range;
      logic [CH_W-1:0] hue;
      logic [CH_W-1:0] sat;
      logic [CH_W-1:0] bright;
   } hsv_result_type;

   // keeps a copy of the bounds, predicts each pixel and checks the result stream
   class hsv_tracker_type;
      logic [CH_W-1:0] hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi;
      hsv_result_type  expected_hsv[$];
      int              errors;
      int              results_seen;

      function new();
         errors       = 0;
         results_seen = 0;
         hue_lo = 8'd0;
         hue_hi = 8'd255;
         sat_lo = 8'd0;
         sat_hi = 8'd255;
         val_lo = 8'd0;
         val_hi = 8'd255;
      endfunction

      function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CH_W-1:0] v);
         case (idx)
            REG_HUE_LOW:  hue_lo = v;
            REG_HUE_HIGH: hue_hi = v;
            REG_SAT_LOW:  sat_lo = v;
            REG_SAT_HIGH: sat_hi = v;
            REG_VAL_LOW:  val_lo = v;
            REG_VAL_HIGH: val_hi = v;
            default: ;
         endcase
      endfunction

      function hsv_result_type hsv_of_pixel(logic [PIX_W-1:0] px);
         int             r, g, b, mx, mn, diff, deg;
         logic           ok;
         hsv_result_type res;
         r = (int'(px[15:11]) * 255) / 31;
         g = (int'(px[10:5]) * 255) / 63;
         b = (int'(px[4:0]) * 255) / 31;
         mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
         mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
         res.hue    = '0;
         res.sat    = '0;
         res.bright = mx[CH_W-1:0];
         if (mx != 0) begin
            diff = mx - mn;
            res.sat = CH_W'((diff * 255) / mx);
            if (diff != 0) begin
               // red is tested first, then green
               if (mx == r)
                  deg = ((g - b) * 60) / diff;
               else if (mx == g)
                  deg = ((b - r) * 60) / diff + 120;
               else
                  deg = ((r - g) * 60) / diff + 240;
               if (deg < 0)
                  deg += 360;
               res.hue = CH_W'((deg * 255) / 360);
            end
         end
         ok = res.sat >= sat_lo && res.sat <= sat_hi &&
              res.bright >= val_lo && res.bright <= val_hi;
         if (ok) begin
            if (hue_lo <= hue_hi)
               ok = res.hue >= hue_lo && res.hue <= hue_hi;
            else
               ok = res.hue >= hue_lo || res.hue <= hue_hi;
         end
         res.in_range = ok;
         return res;
      endfunction

      function void note_pixel(logic [PIX_W-1:0] px);
         expected_hsv.push_back(hsv_of_pixel(px));
      endfunction

      function void check_result(logic [RSP_W-1:0] beat);
         hsv_result_type got, want;
         got.in_range = beat[0];
         got.hue      = beat[8:1];
         got.sat      = beat[16:9];
         got.bright   = beat[24:17];
         results_seen++;
         if (expected_hsv.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display({"result beat %0d arrived with nothing pending: ",
                         "match=%0d h=%0d s=%0d v=%0d"},
                        results_seen, got.in_range, got.hue, got.sat, got.bright);
            return;
         end
         want = expected_hsv.pop_front();
         if (got.in_range !== want.in_range || got.hue !== want.hue ||
             got.sat !== want.sat || got.bright !== want.bright) begin
            errors++;
            if (errors <= 10)
               $display({"result beat %0d: expected match=%0d h=%0d s=%0d v=%0d, ",
                         "got match=%0d h=%0d s=%0d v=%0d"},
                        results_seen, want.in_range, want.hue, want.sat, want.bright,
                        got.in_range, got.hue, got.sat, got.bright);
         end
      endfunction

      function int pending();
         return expected_hsv.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_wen     = 1'b0;
   logic [CFG_IDX_W-1:0]  csr_addr    = '0;
   logic [CH_W-1:0]       csr_wdata   = '0;

   hsv_tracker_type board = new();

   rgb565_hsv_color_range_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] pixel_rgb565
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [0] in_range, [8:1] hue, [16:9] sat, [24:17] brightness
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver: alternates ready and stalled runs, now and then a long ready stretch
   int ready_left  = 0;
   bit ready_state = 1'b0;

   always @(posedge clock) begin
      if (ready_left > 0) begin
         ready_left--;
      end else begin
         ready_state = !ready_state;
         if (ready_state)
            ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 10);
         else
            ready_left = $urandom_range(0, 14);
      end
      rsp_tready <= ready_state;
   end

   // every accepted result beat goes to the checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata);
   end

   // hang detection: count cycles with no beat on either side
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("no beat moved for %0d cycles, giving up", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // block until every predicted result has come back, always advances at least once
   task automatic wait_drained();
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // one register write, the model follows at the same edge
   task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CH_W-1:0] v);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.set_reg(idx, v);
   endtask

   // all six bounds, then junk to the two unmapped indexes
   task automatic program_bounds(input logic [CH_W-1:0] hl, hh, sl, sh, vl, vh);
      write_reg(REG_HUE_LOW, hl);
      write_reg(REG_HUE_HIGH, hh);
      write_reg(REG_SAT_LOW, sl);
      write_reg(REG_SAT_HIGH, sh);
      write_reg(REG_VAL_LOW, vl);
      write_reg(REG_VAL_HIGH, vh);
      write_reg(REG_UNMAPPED_LO, CH_W'($urandom));
      write_reg(REG_UNMAPPED_HI, CH_W'($urandom));
      csr_wen <= 1'b0;
   endtask

   // low/high pair, mostly ordered, sometimes swapped so nothing can match unless the two are equal
   function automatic logic [15:0] bound_pair();
      logic [7:0] lo, hi;
      lo = 8'($urandom_range(0, 160));
      hi = 8'($urandom_range(lo, 255));
      if ($urandom_range(0, 7) == 0)
         return {lo, hi};
      return {hi, lo};
   endfunction

   // pixel mix: mostly raw noise, plus grays, strong primaries and tied maxima
   function automatic logic [PIX_W-1:0] pick_pixel();
      logic [4:0] r5, b5;
      logic [5:0] g6;
      r5 = 5'($urandom);
      g6 = 6'($urandom);
      b5 = 5'($urandom);
      case ($urandom_range(0, 9))
         6: begin
            // near-gray: green about twice red, blue equal to red
            b5 = r5;
            g6 = {r5, 1'($urandom)};
         end
         7: begin
            case ($urandom_range(0, 2))
               0: r5 = 5'h1F;
               1: g6 = 6'h3F;
               default: b5 = 5'h1F;
            endcase
         end
         8: begin
            // tied maxima exercise the red-over-green-over-blue priority
            case ($urandom_range(0, 2))
               0: begin r5 = 5'h1F; g6 = 6'h3F; end
               1: begin g6 = 6'h3F; b5 = 5'h1F; end
               default: begin r5 = 5'h1F; b5 = 5'h1F; end
            endcase
         end
         9: begin
            r5 = {5{r5[0]}};
            g6 = {6{r5[0]}};
            b5 = {5{r5[0]}};
         end
         default: ;
      endcase
      return {r5, g6, b5};
   endfunction

   // push a list of pixels in bursts, with gaps and the odd full drain between bursts
   task automatic send_stream(input logic [PIX_W-1:0] pix_list[$]);
      int left;
      int gap;
      left = $urandom_range(1, 24);
      foreach (pix_list[i]) begin
         req_tvalid <= 1'b1;
         req_tdata  <= pix_list[i];
         do @(posedge clock); while (!req_tready);
         board.note_pixel(pix_list[i]);
         left--;
         if (left == 0 && i != pix_list.size() - 1) begin
            gap  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 24);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               req_tdata  <= PIX_W'($urandom);
               if ($urandom_range(0, 11) == 0)
                  wait_drained();
               else
                  repeat (gap) @(posedge clock);
            end
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic send_random(input int count);
      logic [PIX_W-1:0] pix_list[$];
      repeat (count) pix_list.push_back(pick_pixel());
      send_stream(pix_list);
   endtask

   // reset, then directed corners, then fixed and random bound settings
   initial begin
      logic [PIX_W-1:0] corner_pix[$];
      logic [15:0]      sat_pair, val_pair;
      logic [7:0]       hl, hh;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset bounds are full range, so every corner should match
      corner_pix = '{
         16'h0000,   // black
         16'hFFFF,   // white
         16'h0841,   // dim gray, all channels expand to 8
         16'h8410,   // mid level, channels close but not equal
         16'hF800,   // pure red
         16'h07E0,   // pure green
         16'h001F,   // pure blue
         16'hFFE0,   // red ties green
         16'h07FF,   // green ties blue
         16'hF81F,   // red ties blue
         16'hF810,   // red max with blue above green, hue wraps below zero
         16'hF801,   // red max, tiny blue
         16'h8001,
         16'h0001,
         16'h0020,
         16'h0800,
         16'h7BEF,
         16'h03FF,   // blue max with green above red
         16'hA5A5,
         16'h5A5A,
         16'h1234,
         16'hF7DE
      };
      send_stream(corner_pix);

      // wrapped hue window with moderate saturation and value floors
      wait_drained();
      program_bounds(8'd200, 8'd40, 8'd50, 8'd255, 8'd30, 8'd255);
      send_random(45);

      // saturation window inverted: nothing passes
      wait_drained();
      program_bounds(8'd0, 8'd255, 8'd200, 8'd100, 8'd0, 8'd255);
      send_random(30);

      // value window inverted: nothing passes
      wait_drained();
      program_bounds(8'd0, 8'd255, 8'd0, 8'd255, 8'd220, 8'd30);
      send_random(30);

      // everything pinned at zero, only black fits
      wait_drained();
      program_bounds(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_random(35);

      // everything pinned at the top
      wait_drained();
      program_bounds(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      send_random(35);

      // hue exactly zero: grays and red-axis pixels
      wait_drained();
      program_bounds(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255);
      send_random(35);

      // widest wrap, hue at least 255 or at most 0
      wait_drained();
      program_bounds(8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255);
      send_random(35);

      // random windows
      repeat (4) begin
         wait_drained();
         hl       = 8'($urandom);
         hh       = 8'($urandom);
         sat_pair = bound_pair();
         val_pair = bound_pair();
         program_bounds(hl, hh, sat_pair[7:0], sat_pair[15:8], val_pair[7:0], val_pair[15:8]);
         send_random(40);
      end

      // drain, then let the pipe sit quiet to catch stray beats
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         $display("%0d predicted results never arrived", board.pending());
         board.errors++;
      end
      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
